// ===== rtl/detection_vote_tracker_defines.svh =====
// Assertion macros for the detection vote tracker checker.
`ifndef DETECTION_VOTE_TRACKER_DEFINES_SVH
`define DETECTION_VOTE_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is held.
`define DVT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is held.
`define DVT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dvt_pkg.sv =====
// Shared types and constants for the detection vote tracker.
package dvt_pkg;

	localparam int CX_W      = 12;
	localparam int RAD_W     = 16;
	localparam int VOTE_W    = 8;
	localparam int IDX_OUT_W = 6;

	localparam logic [VOTE_W-1:0] VOTE_SAT       = 8'hFF;
	localparam logic [VOTE_W-1:0] VOTE_LIMIT_RST = 8'd20;

	// one table entry as stored in the entry RAM
	typedef struct packed {
		logic [CX_W-1:0]   cx;
		logic [CX_W-1:0]   cy;
		logic [RAD_W-1:0]  radius;
		logic [VOTE_W-1:0] votes;
	} entry_t;

	// one result word handed from the scan engine to the output register
	typedef struct packed {
		logic                 matched;
		logic                 inserted;
		logic                 dropped;
		logic [IDX_OUT_W-1:0] entry_index;
		logic [VOTE_W-1:0]    vote_count;
		logic                 light_found;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_POST
	} scan_state_t;

endpackage

// ===== rtl/detection_vote_tracker.sv =====
// Top level of the detection vote tracker: config register, scan engine, RAM, result register.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------------
//  det      | det_valid / det_stall   | center_x, center_y, radius_q4
//  res      | res_valid / res_stall   | matched, inserted, dropped, entry_index,
//           |                         | vote_count, light_found
//  cfg      | cfg_valid / cfg_ready   | cfg_data (vote limit)
//
// Per word, from accept to result, the scan makes one RAM read per entry in the
// table (at most CAPACITY) through the single read port, waits for the registered
// read data and for the read pipe to settle, then writes back and hands off.
// The next det word is taken in the cycle after the result lands in the output
// register, even while res_stall holds it there. While an untaken result
// blocks the output register the scan waits in its hand-off state and
// det_stall stays high.
// Reset empties the table (count only, RAM contents are not cleared), clears the
// found flag and loads the vote limit with 20. cfg is always ready.
module detection_vote_tracker #(
	parameter int CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// detection input
	input  logic                          det_valid,
	output logic                          det_stall,
	input  logic [dvt_pkg::CX_W-1:0]      center_x,
	input  logic [dvt_pkg::CX_W-1:0]      center_y,
	input  logic [dvt_pkg::RAD_W-1:0]     radius_q4,
	// result output
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          matched,
	output logic                          inserted,
	output logic                          dropped,
	output logic [dvt_pkg::IDX_OUT_W-1:0] entry_index,
	output logic [dvt_pkg::VOTE_W-1:0]    vote_count,
	output logic                          light_found,
	// vote limit write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dvt_pkg::VOTE_W-1:0]    cfg_data
);
	import dvt_pkg::*;

	// address and fill-count widths follow the table depth
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int UW = $clog2(CAPACITY + 1);

	logic [VOTE_W-1:0] vote_limit_q;
	logic              res_valid_q;
	res_t              res_q;
	res_t              scan_res;
	logic              res_push;
	logic              out_free;
	logic              busy;
	logic              rd_en, wr_en;
	logic [AW-1:0]     rd_addr, wr_addr;
	entry_t            rd_data, wr_data;

	// config is taken any cycle; writes must come only while idle, which the block does not enforce
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vote_limit_q <= VOTE_LIMIT_RST;
		end else if (cfg_valid) begin
			vote_limit_q <= cfg_data;
		end
	end

	// output register frees up in the same cycle its word is taken
	assign out_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_push) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q <= scan_res;
		end
	end

	assign det_stall   = busy;
	assign res_valid   = res_valid_q;
	assign matched     = res_q.matched;
	assign inserted    = res_q.inserted;
	assign dropped     = res_q.dropped;
	assign entry_index = res_q.entry_index;
	assign vote_count  = res_q.vote_count;
	assign light_found = res_q.light_found;

	dvt_scan #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.UW       (UW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.det_valid  (det_valid),
		.busy       (busy),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius_q4  (radius_q4),
		.vote_limit (vote_limit_q),
		.out_free   (out_free),
		.res_push   (res_push),
		.res        (scan_res),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	// one packed word per entry: centre, radius, votes
	dvt_entry_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

endmodule

// ===== rtl/dvt_entry_ram.sv =====
// Entry table RAM: one write port, one read port, registered read data.
module dvt_entry_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output dvt_pkg::entry_t  rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  dvt_pkg::entry_t  wr_data
);
	import dvt_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/dvt_scan.sv =====
// Scan engine: walks the entry RAM top down, votes or appends (or drops when the table is full), writes back.
module dvt_scan #(
	parameter int CAPACITY = 64,
	parameter int AW       = 6,
	parameter int UW       = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          det_valid,
	output logic                          busy,
	input  logic [dvt_pkg::CX_W-1:0]      center_x,
	input  logic [dvt_pkg::CX_W-1:0]      center_y,
	input  logic [dvt_pkg::RAD_W-1:0]     radius_q4,
	input  logic [dvt_pkg::VOTE_W-1:0]    vote_limit,
	input  logic                          out_free,
	output logic                          res_push,
	output dvt_pkg::res_t                 res,
	output logic                          rd_en,
	output logic [AW-1:0]                 rd_addr,
	input  dvt_pkg::entry_t               rd_data,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output dvt_pkg::entry_t               wr_data
);
	import dvt_pkg::*;

	// open-square test on one axis, 12.4 units: |a - b| * 16 < r
	function automatic logic axis_hit(input logic [CX_W-1:0] a, input logic [CX_W-1:0] b,
			input logic [RAD_W-1:0] r);
		logic [CX_W-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return {d, 4'b0000} < r;
	endfunction

	scan_state_t state_q, state_d;

	logic [CX_W-1:0]   x_q, y_q;
	logic [RAD_W-1:0]  r_q;
	logic [UW-1:0]     used_q;
	logic [UW-1:0]     issue_cnt_q;
	logic [UW-1:0]     cnt_dec;
	logic              rv_s1;
	logic [AW-1:0]     ra_s1;
	logic              hit_q;
	logic [AW-1:0]     hit_idx_q;
	entry_t            hit_word_q;
	logic              over_q;
	logic              found_q;
	res_t              res_q;
	logic              full;
	logic              hit_now;
	logic              first_hit;
	logic [VOTE_W-1:0] sat_votes;
	logic              over_now;
	logic              accept;

	assign full      = (used_q == UW'(CAPACITY));
	assign cnt_dec   = issue_cnt_q - UW'(1);
	assign hit_now   = rv_s1 && axis_hit(x_q, rd_data.cx, rd_data.radius)
	                         && axis_hit(y_q, rd_data.cy, rd_data.radius);
	assign first_hit = hit_now && !hit_q;
	assign sat_votes = (rd_data.votes == VOTE_SAT) ? rd_data.votes
	                                               : rd_data.votes + VOTE_W'(1);
	// the first hit is checked with its new count, all others with the stored one
	assign over_now  = rv_s1 && (first_hit ? (sat_votes > vote_limit)
	                                       : (rd_data.votes > vote_limit));
	assign accept    = det_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		busy     = 1'b1;
		rd_en    = 1'b0;
		rd_addr  = cnt_dec[AW-1:0];
		wr_en    = 1'b0;
		wr_addr  = hit_q ? hit_idx_q : used_q[AW-1:0];
		wr_data  = hit_q ? hit_word_q : entry_t'{cx: x_q, cy: y_q, radius: r_q, votes: '0};
		res_push = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (det_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = (issue_cnt_q != '0);
				if ((issue_cnt_q == '0) && !rv_s1) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				wr_en   = hit_q || !full;
				state_d = ST_POST;
			end
			ST_POST: begin
				res_push = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			found_q     <= 1'b0;
			issue_cnt_q <= '0;
			rv_s1       <= 1'b0;
			hit_q       <= 1'b0;
			over_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= rd_en;
			if (accept) begin
				issue_cnt_q <= used_q;
				hit_q       <= 1'b0;
				over_q      <= 1'b0;
			end else begin
				if (rd_en) begin
					issue_cnt_q <= cnt_dec;
				end
				if (first_hit) begin
					hit_q <= 1'b1;
				end
				if (over_now) begin
					over_q <= 1'b1;
				end
			end
			if (state_q == ST_WRITE) begin
				found_q <= found_q | over_q;
				if (!hit_q && !full) begin
					used_q <= used_q + UW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= center_x;
			y_q <= center_y;
			r_q <= radius_q4;
		end
		ra_s1 <= rd_addr;
		if (first_hit) begin
			hit_idx_q  <= ra_s1;
			hit_word_q <= '{cx: rd_data.cx, cy: rd_data.cy, radius: rd_data.radius,
			                votes: sat_votes};
		end
		if (state_q == ST_WRITE) begin
			res_q.matched     <= hit_q;
			res_q.inserted    <= !hit_q && !full;
			res_q.dropped     <= !hit_q && full;
			res_q.entry_index <= hit_q ? IDX_OUT_W'(hit_idx_q)
			                     : (full ? '0 : IDX_OUT_W'(used_q[AW-1:0]));
			res_q.vote_count  <= hit_q ? hit_word_q.votes : '0;
			res_q.light_found <= found_q | over_q;
		end
	end

	assign res = res_q;

endmodule

// ===== rtl/dvt_checker.sv =====
// Port-level checker for the detection vote tracker, bound to the top level.
`include "detection_vote_tracker_defines.svh"

module dvt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_stall,
	input logic                          matched,
	input logic                          inserted,
	input logic                          dropped,
	input logic [dvt_pkg::IDX_OUT_W-1:0] entry_index,
	input logic [dvt_pkg::VOTE_W-1:0]    vote_count,
	input logic                          light_found
);
	import dvt_pkg::*;

	// every result word reports exactly one outcome
	`DVT_ASSERT_NOW(a_one_outcome, res_valid, $onehot({matched, inserted, dropped}), "result outcome not one-hot")

	// a dropped word carries zero index and zero votes
	`DVT_ASSERT_NOW(a_drop_zero, res_valid && dropped, (entry_index == '0) && (vote_count == '0), "dropped word has nonzero fields")

	// a fresh entry starts at zero votes
	`DVT_ASSERT_NOW(a_insert_zero, res_valid && inserted, vote_count == '0, "inserted word has votes")

	// found flag never falls once reported
	`DVT_ASSERT_NEXT(a_found_sticky, res_valid && light_found, light_found, "light_found cleared")

	// a stalled result word stays put
	`DVT_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(vote_count) && $stable(entry_index), "stalled result changed")

endmodule

bind detection_vote_tracker dvt_checker u_dvt_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for detection_vote_tracker against a table predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dvt_pkg::*;

	localparam int CAPACITY  = 64;
	localparam int LONG_HOLD = 400;	// cycles of res_stall for the long receiver hold-off

	// Scoreboard: keeps its own copy of the vote table, predicts one outcome per detection
	// word and checks result words against the oldest prediction.
	class vote_scoreboard;
		logic [CX_W-1:0]   ent_cx[CAPACITY];
		logic [CX_W-1:0]   ent_cy[CAPACITY];
		logic [RAD_W-1:0]  ent_rad[CAPACITY];
		logic [VOTE_W-1:0] ent_votes[CAPACITY];
		int unsigned       used;
		bit                found;
		logic [VOTE_W-1:0] vote_limit;
		res_t              outcome_q[$];
		int unsigned       n_results;
		int unsigned       n_errors;

		function new();
			used       = 0;
			found      = 1'b0;
			vote_limit = VOTE_LIMIT_RST;
			n_results  = 0;
			n_errors   = 0;
		endfunction

		// open square along one axis, 12.4 units: |a - b| * 16 < r
		function bit in_square(logic [CX_W-1:0] a, logic [CX_W-1:0] b,
				logic [RAD_W-1:0] r);
			logic [CX_W-1:0] d;
			d = (a >= b) ? a - b : b - a;
			return {d, 4'b0000} < r;
		endfunction

		function void note_detection(logic [CX_W-1:0] x, logic [CX_W-1:0] y,
				logic [RAD_W-1:0] r);
			res_t want;
			int   k;
			want = '0;
			// newest entry first, first hit wins
			for (k = int'(used) - 1; k >= 0; k--) begin
				if (!want.matched && in_square(x, ent_cx[k], ent_rad[k]) &&
						in_square(y, ent_cy[k], ent_rad[k])) begin
					if (ent_votes[k] != VOTE_SAT)
						ent_votes[k] = ent_votes[k] + 1'b1;
					want.matched     = 1'b1;
					want.entry_index = k[IDX_OUT_W-1:0];
					want.vote_count  = ent_votes[k];
				end
			end
			if (!want.matched) begin
				if (used < CAPACITY) begin
					ent_cx[used]     = x;
					ent_cy[used]     = y;
					ent_rad[used]    = r;
					ent_votes[used]  = '0;
					want.inserted    = 1'b1;
					want.entry_index = used[IDX_OUT_W-1:0];
					used++;
				end else begin
					want.dropped = 1'b1;
				end
			end
			// sticky flag, rescanned every step (drops too)
			for (k = 0; k < int'(used); k++)
				if (ent_votes[k] > vote_limit)
					found = 1'b1;
			want.light_found = found;
			outcome_q = {outcome_q, want};
		endfunction

		task report(string msg);
			n_errors++;
			$display("[%0t] result %0d: %s", $time, n_results, msg);
		endtask

		task cmp(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("%s is %0h, expected %0h", name, got, want));
		endtask

		task check_outcome(res_t got);
			res_t want;
			n_results++;
			if (outcome_q.size() == 0) begin
				report($sformatf("result word with no detection pending: %p", got));
				return;
			end
			want = outcome_q.pop_front();
			cmp("matched", 8'(got.matched), 8'(want.matched));
			cmp("inserted", 8'(got.inserted), 8'(want.inserted));
			cmp("dropped", 8'(got.dropped), 8'(want.dropped));
			cmp("entry_index", 8'(got.entry_index), 8'(want.entry_index));
			cmp("vote_count", got.vote_count, want.vote_count);
			cmp("light_found", 8'(got.light_found), 8'(want.light_found));
		endtask
	endclass

	// DUT-facing signals; everything the TB drives starts at a known value
	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 det_valid  = 1'b0;
	logic                 det_stall;
	logic [CX_W-1:0]      center_x   = '0;
	logic [CX_W-1:0]      center_y   = '0;
	logic [RAD_W-1:0]     radius_q4  = '0;
	logic                 res_valid;
	logic                 res_stall  = 1'b0;
	logic                 matched;
	logic                 inserted;
	logic                 dropped;
	logic [IDX_OUT_W-1:0] entry_index;
	logic [VOTE_W-1:0]    vote_count;
	logic                 light_found;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [VOTE_W-1:0]    cfg_data   = '0;

	vote_scoreboard sb = new();

	res_t        seen_res;
	int unsigned stall_left = 0;	// receiver: cycles of stall still to go
	int unsigned quiet_left = 0;	// receiver: cycles with no stall at all
	int unsigned burst_left = 0;	// sender: words to send back to back

	detection_vote_tracker #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.det_valid  (det_valid),
		.det_stall  (det_stall),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius_q4  (radius_q4),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.matched    (matched),
		.inserted   (inserted),
		.dropped    (dropped),
		.entry_index(entry_index),
		.vote_count (vote_count),
		.light_found(light_found),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Idle length: mostly none, often short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return 0;
		if (sel < 88)
			return $urandom_range(1, 3);
		if (sel < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	// Radius for a new word. Huge values only once the table is full, where they
	// are never stored; a stored huge square would swallow every later detection.
	function automatic logic [RAD_W-1:0] pick_radius();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 6)
			return '0;
		if (sb.used == CAPACITY && sel < 30)
			return RAD_W'($urandom);
		return RAD_W'($urandom_range(1, 1200));
	endfunction

	// Coordinate near a stored centre. dmax is the largest offset still inside;
	// with hug set the offset sits right on the border, one side or the other.
	function automatic logic [CX_W-1:0] near(logic [CX_W-1:0] c, int unsigned dmax, bit hug);
		int unsigned off;
		int          p;
		off = hug ? dmax + $urandom_range(0, 1) : $urandom_range(0, dmax);
		p = $urandom_range(0, 1) ? int'(c) + int'(off) : int'(c) - int'(off);
		if (p > 4095)
			p = int'(c) - int'(off);
		if (p < 0)
			p = int'(c) + int'(off);
		if (p > 4095)
			p = 4095;
		return p[CX_W-1:0];
	endfunction

	task automatic make_detection(output logic [CX_W-1:0] x, output logic [CX_W-1:0] y,
			output logic [RAD_W-1:0] r);
		int unsigned mode, k, dmax;
		mode = $urandom_range(0, 99);
		r = pick_radius();
		x = CX_W'($urandom_range(0, 4095));
		y = CX_W'($urandom_range(0, 4095));
		if (mode < 60 && sb.used > 0) begin
			// aim at a stored entry, a third of those right on its border
			k = $urandom_range(0, sb.used - 1);
			dmax = (sb.ent_rad[k] == 0) ? 0 : (sb.ent_rad[k] - 1) >> 4;
			x = near(sb.ent_cx[k], dmax, mode < 20);
			y = near(sb.ent_cy[k], dmax, mode < 20);
		end else if (sb.used == CAPACITY - 1 && mode < 80) begin
			// last free slot: a large square anchored in a corner, covering
			// part of the frame only, so drops still happen afterwards
			x = $urandom_range(0, 1) ? '1 : '0;
			y = $urandom_range(0, 1) ? '1 : '0;
			r = RAD_W'($urandom_range(16'h6000, 16'h8FFF));
		end
	endtask

	// Offer one detection word, note it at acceptance, then idle for a random gap, which may be none.
	task automatic offer(input logic [CX_W-1:0] x, input logic [CX_W-1:0] y,
			input logic [RAD_W-1:0] r);
		int unsigned gap;
		det_valid <= 1'b1;
		center_x  <= x;
		center_y  <= y;
		radius_q4 <= r;
		do
			@(posedge clk);
		while (det_stall);
		sb.note_detection(x, y, r);
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 39) == 0)
				burst_left = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			det_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every predicted result word has come back.
	task automatic drain();
		det_valid <= 1'b0;
		while (sb.outcome_q.size() != 0)
			@(posedge clk);
	endtask

	// the vote limit changes only with the block idle
	task automatic write_limit(input logic [VOTE_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.vote_limit = v;
	endtask

	task automatic run_random(int unsigned n);
		logic [CX_W-1:0]  x, y;
		logic [RAD_W-1:0] r;
		repeat (n) begin
			make_detection(x, y, r);
			offer(x, y, r);
		end
	endtask

	// Hammer the newest entry that can match at all, to drive its count into
	// saturation. Entries above it have zero radius and never match.
	task automatic pound_entry(int unsigned n);
		int k, hit;
		hit = -1;
		for (k = 0; k < int'(sb.used); k++)
			if (sb.ent_rad[k] != 0)
				hit = k;
		if (hit >= 0)
			repeat (n) offer(sb.ent_cx[hit], sb.ent_cy[hit], pick_radius());
	endtask

	// Result side: check every accepted word, then choose the stall for the next
	// cycle. Two long hold-offs make the block back up into det_stall.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			seen_res.matched     = matched;
			seen_res.inserted    = inserted;
			seen_res.dropped     = dropped;
			seen_res.entry_index = entry_index;
			seen_res.vote_count  = vote_count;
			seen_res.light_found = light_found;
			sb.check_outcome(seen_res);
			if (sb.n_results == 600 || sb.n_results == 1400)
				stall_left = LONG_HOLD;
		end
		if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else if (quiet_left > 0) begin
			quiet_left--;
			res_stall <= 1'b0;
		end else begin
			if ($urandom_range(0, 49) == 0)
				quiet_left = $urandom_range(30, 120);
			stall_left = pick_gap();
			res_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, vote limit still at its reset value. Table starts empty.
		offer(12'd0, 12'd0, 16'd0);		// zero radius entry, can never match
		offer(12'd0, 12'd0, 16'd16);		// skips it, inserts; half-side is 0 px
		offer(12'd0, 12'd0, 16'd5);		// same centre: vote
		offer(12'd1, 12'd0, 16'd5);		// 1 px off, 16 < 16 fails: insert
		offer(12'd0, 12'd1, 16'd9);
		offer(12'd4095, 12'd4095, 16'd17);	// far corner, 1 px reach
		offer(12'd4094, 12'd4094, 16'd0);	// diagonal neighbour: vote
		offer(12'd4093, 12'd4095, 16'd0);	// 2 px off: insert
		offer(12'd4095, 12'd0, 16'd4095);	// 255 px reach
		offer(12'd3840, 12'd255, 16'd0);	// exactly 255 px on both axes: vote
		offer(12'd3839, 12'd0, 16'd0);		// 256 px, just outside: insert
		offer(12'd4095, 12'd0, 16'd0);
		offer(12'd0, 12'd4095, 16'd32);
		offer(12'd1, 12'd4094, 16'd0);
		offer(12'd2, 12'd4095, 16'd0);		// 32 < 32 fails: insert
		offer(12'd4095, 12'd4095, 16'd0);	// falls through to an older entry

		// Fill the table and keep voting at the reset threshold.
		run_random(380);

		// Highest threshold: flag can never set; one entry saturates at 255.
		write_limit(8'd255);
		run_random(150);
		drain();
		run_random(150);
		pound_entry(270);

		// Zero threshold: any voted entry sets the flag on the next step, drops too.
		write_limit(8'd0);
		run_random(400);

		write_limit(VOTE_W'($urandom_range(1, 254)));
		run_random(500);

		drain();
		repeat (100) @(posedge clk);	// catch any stray result word
		if (sb.n_errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
